@@ rtl/itoa_pkg.sv @@
// Package for the integer to radix text unit.
// Holds shared widths, codes, control structs and the digit and radix helpers.
// No dependencies.
package itoa_pkg;

	// Default sizing of the number path and the digit stack.
	localparam int VALUE_BITS = 32;
	localparam int MAX_DIGITS = 32;

	// Field widths fixed by the item formats.
	localparam int RADIX_W = 6;
	localparam int CHAR_W  = 8;

	// APB register file: one 32-bit register per word.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Register index, taken from the word address bit.
	localparam logic REG_RADIX = 1'b0;

	// Radix limits and special values.
	localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;

	// Character codes.
	localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_LETTER = 8'h41;

	// Highest digit value that has a character.
	localparam logic [RADIX_W-1:0] DIGIT_TOP = 6'd35;
	localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

	// Commands from the sequencer to the divider.
	typedef struct packed {
		logic load;
		logic start;
	} div_ctrl_t;

	// Status from the divider back to the sequencer.
	typedef struct packed {
		logic done;
		logic zero;
	} div_stat_t;

	// Bound the programmed radix to the supported range.
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	// Map a digit value to its upper-case ASCII character.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [RADIX_W-1:0] dc;
		logic [CHAR_W-1:0]  res;
		dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
		if (dc < DIGIT_TEN) begin
			res = CHAR_ZERO + {2'b00, dc};
		end else begin
			res = CHAR_LETTER + {2'b00, dc - DIGIT_TEN};
		end
		return res;
	endfunction

endpackage

@@ rtl/itoa_in_if.sv @@
// Input channel of the integer to radix text unit: one signed number per item.
// Depends on itoa_pkg for the default number width.
interface itoa_in_if #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/itoa_out_if.sv @@
// Output channel of the integer to radix text unit: one character per item.
// Depends on itoa_pkg for the character width.
interface itoa_out_if ();
	logic                        valid;
	logic                        ready;
	logic [itoa_pkg::CHAR_W-1:0] character;
	logic                        last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/itoa_divider.sv @@
// Bit-serial restoring divider: divides the working quotient by the radix,
// one quotient bit per cycle. Depends on itoa_pkg.
module itoa_divider #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  itoa_pkg::div_ctrl_t               ctrl,
	input  logic [VALUE_BITS-1:0]             load_value,
	input  logic [itoa_pkg::RADIX_W-1:0]      radix,
	output itoa_pkg::div_stat_t               stat,
	output logic [itoa_pkg::RADIX_W-1:0]      digit
);
	localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

	logic [VALUE_BITS-1:0]         quot_q;
	logic [itoa_pkg::RADIX_W-1:0]  rem_q;
	logic [CNT_W-1:0]              bit_cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [itoa_pkg::RADIX_W:0]    trial;
	logic [itoa_pkg::RADIX_W+1:0]  diff;
	logic                          fits;

	// Shift the next dividend bit into the partial remainder and try the radix.
	always_comb begin
		trial = {rem_q, quot_q[VALUE_BITS-1]};
		diff  = {1'b0, trial} - {2'b00, radix};
		fits  = !diff[itoa_pkg::RADIX_W+1];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			done_q <= busy_q && !ctrl.start && (bit_cnt_q == CNT_LAST);
			if (ctrl.start) begin
				busy_q    <= 1'b1;
				bit_cnt_q <= '0;
			end else if (busy_q) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
				if (bit_cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Quotient and remainder shift registers.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quot_q <= load_value;
		end else if (busy_q) begin
			quot_q <= {quot_q[VALUE_BITS-2:0], fits};
		end
		if (ctrl.start) begin
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[itoa_pkg::RADIX_W-1:0] : trial[itoa_pkg::RADIX_W-1:0];
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (quot_q == '0);
	assign digit     = rem_q;
endmodule

@@ rtl/itoa_digit_stack.sv @@
// Digit stack: holds the digits of one number, least significant first,
// and maps the digit at the read pointer to its character. Depends on itoa_pkg.
module itoa_digit_stack #(
	parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [$clog2(MAX_DIGITS)-1:0]          waddr,
	input  logic [itoa_pkg::RADIX_W-1:0]           wdata,
	input  logic [$clog2(MAX_DIGITS)-1:0]          raddr,
	output logic [itoa_pkg::CHAR_W-1:0]            character
);
	logic [itoa_pkg::RADIX_W-1:0] store_q [MAX_DIGITS];

	// One digit written per finished division.
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
	end

	// Digits are read back in reverse order and turned into text.
	assign character = itoa_pkg::digit_char(store_q[raddr]);
endmodule

@@ rtl/integer_to_radix_ascii_unit.sv @@
// Top level of the integer to radix text unit, with the APB radix register.
// Depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_divider, itoa_digit_stack.

// Converts each accepted number to its text in the programmed radix (2 to 36,
// values outside are clamped), most significant digit first, one ASCII
// character per output item, with last set on the final character. A minus
// sign leads only in radix ten for a negative value; other radixes show the
// unsigned two's-complement pattern. Each digit takes a full pass of the
// bit-serial divider, one quotient bit per cycle; the characters then follow
// at one per cycle while the output side does not stall. A new number is
// accepted once the last character has been handed to the output register.
// The radix register sits at byte address 0, resets to ten, and must be
// written only while the unit is idle.
module integer_to_radix_ascii_unit #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS,
	parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	itoa_in_if.sink                            num,
	itoa_out_if.source                         txt,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [itoa_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [itoa_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [itoa_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);
	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t                         state_q;
	logic [itoa_pkg::RADIX_W-1:0]   radix_q;
	logic [itoa_pkg::RADIX_W-1:0]   radix_eff;
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               count_inc;
	logic                           minus_q;
	logic                           out_valid_q;
	logic [itoa_pkg::CHAR_W-1:0]    out_char_q;
	logic                           out_last_q;

	logic                           in_accept;
	logic                           slot_free;
	logic                           emit_now;
	logic                           minus;
	logic [VALUE_BITS-1:0]          value_u;
	logic [VALUE_BITS-1:0]          magnitude;
	itoa_pkg::div_ctrl_t            div_ctrl;
	itoa_pkg::div_stat_t            div_stat;
	logic [itoa_pkg::RADIX_W-1:0]   div_digit;
	logic                           stack_we;
	logic [IDX_W-1:0]               stack_raddr;
	logic [itoa_pkg::CHAR_W-1:0]    stack_char;
	logic                           cfg_write;

	// Configuration register.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itoa_pkg::RADIX_RESET;
		end else if (cfg_write && (paddr[2] == itoa_pkg::REG_RADIX)) begin
			radix_q <= pwdata[itoa_pkg::RADIX_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == itoa_pkg::REG_RADIX) begin
			prdata[itoa_pkg::RADIX_W-1:0] = radix_q;
		end
	end

	assign radix_eff = itoa_pkg::clamp_radix(radix_q);

	// Sign handling on the incoming number.
	assign value_u   = num.value;
	assign minus     = (radix_eff == itoa_pkg::RADIX_DECIMAL) && value_u[VALUE_BITS-1];
	assign magnitude = minus ? (~value_u + VALUE_BITS'(1)) : value_u;

	// Handshakes.
	assign num.ready = (state_q == ST_IDLE);
	assign in_accept = num.valid && num.ready;
	assign slot_free = !out_valid_q || txt.ready;
	assign emit_now  = (state_q == ST_EMIT) && slot_free;

	// Divider commands and digit stack access.
	assign div_ctrl.load  = in_accept;
	assign div_ctrl.start = (state_q == ST_START);
	assign stack_we       = (state_q == ST_WAIT) && div_stat.done;
	assign count_inc      = count_q + 1'b1;
	assign stack_raddr    = IDX_W'(count_q - CNT_ONE);

	itoa_divider #(
		.VALUE_BITS (VALUE_BITS)
	) u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (div_ctrl),
		.load_value (magnitude),
		.radix      (radix_eff),
		.stat       (div_stat),
		.digit      (div_digit)
	);

	itoa_digit_stack #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_digit_stack (
		.clk       (clk),
		.we        (stack_we),
		.waddr     (count_q[IDX_W-1:0]),
		.wdata     (div_digit),
		.raddr     (stack_raddr),
		.character (stack_char)
	);

	// Sequencer: divide until the quotient is zero or the stack is full, then emit in reverse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			minus_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (txt.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						minus_q <= minus;
						count_q <= '0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_stat.done) begin
						count_q <= count_inc;
						if (div_stat.zero || (count_inc == CNT_FULL)) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (minus_q) begin
							out_char_q <= itoa_pkg::CHAR_MINUS;
							out_last_q <= 1'b0;
							minus_q    <= 1'b0;
						end else begin
							out_char_q <= stack_char;
							out_last_q <= (count_q == CNT_ONE);
							count_q    <= count_q - CNT_ONE;
							if (count_q == CNT_ONE) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign txt.valid     = out_valid_q;
	assign txt.character = out_char_q;
	assign txt.last      = out_last_q;
endmodule
